>>> design/gsc_pkg.sv
// shared constants, state codes and store command types for the connectivity check
package gsc_pkg;

   localparam int NODES  = 1024;
   localparam int EDGES  = 8192;
   localparam int NODE_W = $clog2(NODES);
   localparam int EDGE_W = $clog2(EDGES);
   localparam int PTR_W  = EDGE_W + 1;
   localparam int CNT_W  = NODE_W + 1;

   localparam logic [PTR_W-1:0] EMPTY_MARK = PTR_W'(EDGES);
   localparam logic [CNT_W-1:0] NODE_LIMIT = CNT_W'(NODES);

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   typedef enum logic [14:0] {
      ST_CLEAR   = 15'h0001,
      ST_IDLE    = 15'h0002,
      ST_LOAD    = 15'h0004,
      ST_ROOT    = 15'h0008,
      ST_ROOT2   = 15'h0010,
      ST_EDGE    = 15'h0020,
      ST_EDGE2   = 15'h0040,
      ST_EDGE3   = 15'h0080,
      ST_POP     = 15'h0100,
      ST_SCC     = 15'h0200,
      ST_SCC2    = 15'h0400,
      ST_PARENT  = 15'h0800,
      ST_PARENT2 = 15'h1000,
      ST_PARENT3 = 15'h2000,
      ST_DONE    = 15'h4000
   } state_type;

   typedef struct packed {
      logic              head_we;
      logic [NODE_W-1:0] head_waddr;
      logic [PTR_W-1:0]  head_wdata;
      logic [NODE_W-1:0] head_raddr;
      logic              edge_we;
      logic [EDGE_W-1:0] edge_waddr;
      logic [PTR_W-1:0]  next_wdata;
      logic [NODE_W-1:0] tgt_wdata;
      logic [EDGE_W-1:0] edge_raddr;
   } es_cmd_type;

   typedef struct packed {
      logic [PTR_W-1:0]  head;
      logic [PTR_W-1:0]  next;
      logic [NODE_W-1:0] tgt;
   } es_rd_type;

   typedef struct packed {
      logic              visit_we;
      logic [NODE_W-1:0] visit_waddr;
      logic [CNT_W-1:0]  visit_wdata;
      logic [NODE_W-1:0] visit_raddr;
      logic              low_we;
      logic [NODE_W-1:0] low_waddr;
      logic [CNT_W-1:0]  low_wdata;
      logic [NODE_W-1:0] low_raddr;
      logic              onstk_we;
      logic [NODE_W-1:0] onstk_waddr;
      logic              onstk_wdata;
      logic [NODE_W-1:0] onstk_raddr;
      logic              nstk_we;
      logic [NODE_W-1:0] nstk_waddr;
      logic [NODE_W-1:0] nstk_wdata;
      logic [NODE_W-1:0] nstk_raddr;
      logic              frame_we;
      logic [NODE_W-1:0] frame_waddr;
      logic [NODE_W-1:0] frame_node;
      logic [PTR_W-1:0]  frame_edge;
      logic [NODE_W-1:0] frame_raddr;
   } ws_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]  visit;
      logic [CNT_W-1:0]  low;
      logic              onstk;
      logic [NODE_W-1:0] nstk;
      logic [NODE_W-1:0] fnode;
      logic [PTR_W-1:0]  fedge;
   } ws_rd_type;

endpackage

>>> design/graph_strong_connectivity_check.sv
// top level of the strongly connected component checker
//
// requests arrive on req_*: tuser is the mode (0 adds an edge, 1 evaluates), tdata carries
// from_node in bits 10:0 and to_node in bits 21:11. an edge request reads the list
// head, then links the edge in. bad endpoints or a full edge store drop the edge
// and set the dropped flag.
// an evaluate request walks nodes 1..node_count (at most 1024) with an explicit stack:
// nodes are scanned as roots, edges walked, nodes popped from the node stack and frames
// returned, all set by one sequencer over memories with a read and a write port. one response
// then goes out on rsp_*, and the graph is cleared by a sweep of the node memories
// before the next request is taken.
// the single csr register is node_count (reset 1), written on csr_valid, always ready;
// write it only while idle.
// reset runs the same clearing sweep; req_tready stays low until it ends.
// the response sits in an output register; if the receiver stalls, it holds, and a
// following evaluate waits at its end until the register is free.
module graph_strong_connectivity_check import gsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data,     // node_count
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // from_node [10:0], to_node [21:11], zero [23:22]
   input  logic        req_tuser,    // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata     // all_connected [0], component_count [11:1],
                                     // edges_dropped [12], zero [15:13]
);

   es_cmd_type       es_cmd;
   es_rd_type        es_rd;
   ws_cmd_type       ws_cmd;
   ws_rd_type        ws_rd;
   logic             rsp_all, rsp_dropped;
   logic [CNT_W-1:0] rsp_count;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {3'b000, rsp_dropped, rsp_count, rsp_all};

   gsc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_mode    (req_tuser),
      .req_from    (req_tdata[10:0]),
      .req_to      (req_tdata[21:11]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_all     (rsp_all),
      .rsp_count   (rsp_count),
      .rsp_dropped (rsp_dropped),
      .es_cmd      (es_cmd),
      .es_rd       (es_rd),
      .ws_cmd      (ws_cmd),
      .ws_rd       (ws_rd)
   );

   gsc_edge_store u_edge_store (
      .clock (clock),
      .cmd   (es_cmd),
      .rd    (es_rd)
   );

   gsc_walk_store u_walk_store (
      .clock (clock),
      .cmd   (ws_cmd),
      .rd    (ws_rd)
   );

endmodule

>>> design/gsc_edge_store.sv
// per-node list heads and the edge link and target memories
module gsc_edge_store import gsc_pkg::*; (
   input  logic       clock,
   input  es_cmd_type cmd,
   output es_rd_type  rd
);

   logic [PTR_W-1:0]  head_mem [NODES];
   logic [PTR_W-1:0]  next_mem [EDGES];
   logic [NODE_W-1:0] tgt_mem  [EDGES];

   always_ff @(posedge clock) begin
      if (cmd.head_we) begin
         head_mem[cmd.head_waddr] <= cmd.head_wdata;
      end
      rd.head <= head_mem[cmd.head_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.edge_we) begin
         next_mem[cmd.edge_waddr] <= cmd.next_wdata;
         tgt_mem[cmd.edge_waddr]  <= cmd.tgt_wdata;
      end
      rd.next <= next_mem[cmd.edge_raddr];
      rd.tgt  <= tgt_mem[cmd.edge_raddr];
   end

endmodule

>>> design/gsc_walk_store.sv
// search memories: discovery numbers, low links, stack marks, node stack and walk frames
module gsc_walk_store import gsc_pkg::*; (
   input  logic       clock,
   input  ws_cmd_type cmd,
   output ws_rd_type  rd
);

   logic [CNT_W-1:0]  visit_mem [NODES];
   logic [CNT_W-1:0]  low_mem   [NODES];
   logic              onstk_mem [NODES];
   logic [NODE_W-1:0] nstk_mem  [NODES];
   logic [NODE_W-1:0] fnode_mem [NODES];
   logic [PTR_W-1:0]  fedge_mem [NODES];

   always_ff @(posedge clock) begin
      if (cmd.visit_we) begin
         visit_mem[cmd.visit_waddr] <= cmd.visit_wdata;
      end
      rd.visit <= visit_mem[cmd.visit_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.low_we) begin
         low_mem[cmd.low_waddr] <= cmd.low_wdata;
      end
      rd.low <= low_mem[cmd.low_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.onstk_we) begin
         onstk_mem[cmd.onstk_waddr] <= cmd.onstk_wdata;
      end
      rd.onstk <= onstk_mem[cmd.onstk_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.nstk_we) begin
         nstk_mem[cmd.nstk_waddr] <= cmd.nstk_wdata;
      end
      rd.nstk <= nstk_mem[cmd.nstk_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.frame_we) begin
         fnode_mem[cmd.frame_waddr] <= cmd.frame_node;
         fedge_mem[cmd.frame_waddr] <= cmd.frame_edge;
      end
      rd.fnode <= fnode_mem[cmd.frame_raddr];
      rd.fedge <= fedge_mem[cmd.frame_raddr];
   end

endmodule

>>> design/gsc_ctrl.sv
// sequencer: edge loading, iterative component search, clearing sweep and result register
module gsc_ctrl import gsc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [CNT_W-1:0] csr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_mode,
   input  logic [CNT_W-1:0] req_from,
   input  logic [CNT_W-1:0] req_to,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_all,
   output logic [CNT_W-1:0] rsp_count,
   output logic             rsp_dropped,
   output es_cmd_type       es_cmd,
   input  es_rd_type        es_rd,
   output ws_cmd_type       ws_cmd,
   input  ws_rd_type        ws_rd
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  ncnt_ff, ncnt_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [PTR_W-1:0]  total_ff, total_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  r_ff, r_in, stamp_ff, stamp_in, sp_ff, sp_in, fp_ff, fp_in;
   logic [CNT_W-1:0]  comps_ff, comps_in;
   logic [NODE_W-1:0] u_ff, u_in, v_ff, v_in;
   logic [PTR_W-1:0]  e_ff, e_in;
   logic [CNT_W-1:0]  lowu_ff, lowu_in, visu_ff, visu_in, clow_ff, clow_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_all_ff, rsp_all_in;
   logic              rsp_drop_ff, rsp_drop_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [CNT_W-1:0]  nuse, stamp_p1, sp_m1, fp_m1;
   logic              load_ok, push_en;
   logic [NODE_W-1:0] push_node;
   logic [PTR_W-1:0]  push_head;

   assign nuse     = (ncnt_ff > NODE_LIMIT) ? NODE_LIMIT : ncnt_ff;
   assign stamp_p1 = stamp_ff + CNT_W'(1);
   assign sp_m1    = sp_ff - CNT_W'(1);
   assign fp_m1    = fp_ff - CNT_W'(1);
   assign load_ok  = (a_ff != '0) && (a_ff <= nuse) && (b_ff != '0) && (b_ff <= nuse)
                     && !total_ff[PTR_W-1];

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_all     = rsp_all_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_dropped = rsp_drop_ff;

   always_comb begin
      state_in = state_ff;
      ncnt_in  = csr_valid ? csr_data : ncnt_ff;
      clr_in   = clr_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      total_in = total_ff;
      ovf_in   = ovf_ff;
      r_in     = r_ff;
      stamp_in = stamp_ff;
      sp_in    = sp_ff;
      fp_in    = fp_ff;
      comps_in = comps_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      e_in     = e_ff;
      lowu_in  = lowu_ff;
      visu_in  = visu_ff;
      clow_in  = clow_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff;
      rsp_all_in   = rsp_all_ff;
      rsp_count_in = rsp_count_ff;
      rsp_drop_in  = rsp_drop_ff;
      es_cmd    = '0;
      ws_cmd    = '0;
      push_en   = 1'b0;
      push_node = '0;
      push_head = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            es_cmd.head_we    = 1'b1;
            es_cmd.head_waddr = clr_ff;
            es_cmd.head_wdata = EMPTY_MARK;
            ws_cmd.visit_we    = 1'b1;
            ws_cmd.visit_waddr = clr_ff;
            ws_cmd.onstk_we    = 1'b1;
            ws_cmd.onstk_waddr = clr_ff;
            clr_in = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            es_cmd.head_raddr = NODE_W'(req_from - CNT_W'(1));
            if (req_valid) begin
               if (req_mode == MODE_EVAL) begin
                  r_in     = '0;
                  stamp_in = '0;
                  sp_in    = '0;
                  fp_in    = '0;
                  comps_in = '0;
                  state_in = ST_ROOT;
               end else begin
                  a_in     = req_from;
                  b_in     = req_to;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            if (load_ok) begin
               es_cmd.edge_we    = 1'b1;
               es_cmd.edge_waddr = total_ff[EDGE_W-1:0];
               es_cmd.next_wdata = es_rd.head;
               es_cmd.tgt_wdata  = NODE_W'(b_ff - CNT_W'(1));
               es_cmd.head_we    = 1'b1;
               es_cmd.head_waddr = NODE_W'(a_ff - CNT_W'(1));
               es_cmd.head_wdata = total_ff;
               total_in = total_ff + PTR_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_ROOT: begin
            ws_cmd.visit_raddr = r_ff[NODE_W-1:0];
            es_cmd.head_raddr  = r_ff[NODE_W-1:0];
            state_in = (r_ff == nuse) ? ST_DONE : ST_ROOT2;
         end
         ST_ROOT2: begin
            if (ws_rd.visit != '0) begin
               r_in     = r_ff + CNT_W'(1);
               state_in = ST_ROOT;
            end else begin
               push_en   = 1'b1;
               push_node = r_ff[NODE_W-1:0];
               push_head = es_rd.head;
            end
         end
         ST_EDGE: begin
            es_cmd.edge_raddr = e_ff[EDGE_W-1:0];
            state_in = e_ff[PTR_W-1] ? ST_POP : ST_EDGE2;
         end
         ST_EDGE2: begin
            // keep the top frame and its low link current in memory before any descent
            e_in = es_rd.next;
            ws_cmd.low_we      = 1'b1;
            ws_cmd.low_waddr   = u_ff;
            ws_cmd.low_wdata   = lowu_ff;
            ws_cmd.frame_we    = 1'b1;
            ws_cmd.frame_waddr = fp_m1[NODE_W-1:0];
            ws_cmd.frame_node  = u_ff;
            ws_cmd.frame_edge  = es_rd.next;
            ws_cmd.visit_raddr = es_rd.tgt;
            ws_cmd.onstk_raddr = es_rd.tgt;
            es_cmd.head_raddr  = es_rd.tgt;
            v_in = es_rd.tgt;
            state_in = ({1'b0, es_rd.tgt} >= nuse) ? ST_EDGE : ST_EDGE3;
         end
         ST_EDGE3: begin
            if (ws_rd.visit == '0) begin
               push_en   = 1'b1;
               push_node = v_ff;
               push_head = es_rd.head;
            end else begin
               if (ws_rd.onstk && (ws_rd.visit < lowu_ff)) begin
                  lowu_in = ws_rd.visit;
               end
               state_in = ST_EDGE;
            end
         end
         ST_POP: begin
            fp_in   = fp_m1;
            clow_in = lowu_ff;
            state_in = (lowu_ff == visu_ff) ? ST_SCC : ST_PARENT;
         end
         ST_SCC: begin
            ws_cmd.nstk_raddr = sp_m1[NODE_W-1:0];
            state_in = ST_SCC2;
         end
         ST_SCC2: begin
            ws_cmd.onstk_we    = 1'b1;
            ws_cmd.onstk_waddr = ws_rd.nstk;
            sp_in = sp_m1;
            if ((ws_rd.nstk != u_ff) && (sp_m1 != '0)) begin
               state_in = ST_SCC;
            end else begin
               comps_in = comps_ff + CNT_W'(1);
               state_in = ST_PARENT;
            end
         end
         ST_PARENT: begin
            ws_cmd.frame_raddr = fp_m1[NODE_W-1:0];
            state_in = (fp_ff == '0) ? ST_ROOT : ST_PARENT2;
         end
         ST_PARENT2: begin
            u_in = ws_rd.fnode;
            e_in = ws_rd.fedge;
            ws_cmd.low_raddr   = ws_rd.fnode;
            ws_cmd.visit_raddr = ws_rd.fnode;
            state_in = ST_PARENT3;
         end
         ST_PARENT3: begin
            lowu_in  = (clow_ff < ws_rd.low) ? clow_ff : ws_rd.low;
            visu_in  = ws_rd.visit;
            state_in = ST_EDGE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_all_in   = (comps_ff == CNT_W'(1));
               rsp_count_in = comps_ff;
               rsp_drop_in  = ovf_ff;
               ovf_in   = 1'b0;
               total_in = '0;
               clr_in   = '0;
               state_in = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // new discovery: number it, stack it and open a walk frame
      if (push_en) begin
         ws_cmd.visit_we    = 1'b1;
         ws_cmd.visit_waddr = push_node;
         ws_cmd.visit_wdata = stamp_p1;
         ws_cmd.low_we      = 1'b1;
         ws_cmd.low_waddr   = push_node;
         ws_cmd.low_wdata   = stamp_p1;
         ws_cmd.onstk_we    = 1'b1;
         ws_cmd.onstk_waddr = push_node;
         ws_cmd.onstk_wdata = 1'b1;
         ws_cmd.nstk_we     = 1'b1;
         ws_cmd.nstk_waddr  = sp_ff[NODE_W-1:0];
         ws_cmd.nstk_wdata  = push_node;
         ws_cmd.frame_we    = 1'b1;
         ws_cmd.frame_waddr = fp_ff[NODE_W-1:0];
         ws_cmd.frame_node  = push_node;
         ws_cmd.frame_edge  = push_head;
         stamp_in = stamp_p1;
         sp_in    = sp_ff + CNT_W'(1);
         fp_in    = fp_ff + CNT_W'(1);
         u_in     = push_node;
         e_in     = push_head;
         lowu_in  = stamp_p1;
         visu_in  = stamp_p1;
         state_in = ST_EDGE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ncnt_ff      <= CNT_W'(1);
         clr_ff       <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ncnt_ff      <= ncnt_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      r_ff         <= r_in;
      stamp_ff     <= stamp_in;
      sp_ff        <= sp_in;
      fp_ff        <= fp_in;
      comps_ff     <= comps_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      e_ff         <= e_in;
      lowu_ff      <= lowu_in;
      visu_ff      <= visu_in;
      clow_ff      <= clow_in;
      rsp_all_ff   <= rsp_all_in;
      rsp_count_ff <= rsp_count_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

endmodule

>>> design/gsc_checker.sv
// port-level checks for the connectivity check, bound to the top level
module gsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // connected flag agrees with the count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] == (rsp_tdata[11:1] == 11'd1))
      else $error("all_connected disagrees with component_count");

   // clearing sweep follows reset
   assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing sweep");

   // every taken request leaves the block busy, so requests are never taken back to back
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken back to back");

endmodule

bind graph_strong_connectivity_check gsc_checker u_gsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
